[rtl/pending_request_table_with_timeout_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the pending request table
// Concurrent assertion wrappers that vanish when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef PENDING_REQUEST_TABLE_WITH_TIMEOUT_DEFINES_SVH
`define PENDING_REQUEST_TABLE_WITH_TIMEOUT_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check that is switched off while reset is high.
`define PRTT_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
// Clocked check that also holds during reset.
`define PRTT_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define PRTT_ASSERT(lbl, ck, rs, prop, msg)
`define PRTT_ASSERT_ALWAYS(lbl, ck, prop, msg)
`endif

`endif

[rtl/prtt_pkg.sv]
// ---------------------------------------------------------------------------
// Pending request table package
// Shared constants, codes, types and a helper function.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package prtt_pkg;

  // Table size and derived widths.
  localparam int TABLE_DEPTH = 16;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Input word kinds.
  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_FETCH = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_APPENDED = 3'd0;
  localparam logic [2:0] ST_REPLACED = 3'd1;
  localparam logic [2:0] ST_DROPPED  = 3'd2;
  localparam logic [2:0] ST_HIT      = 3'd3;
  localparam logic [2:0] ST_MISS     = 3'd4;

  // Timeout register value after reset.
  localparam logic [15:0] TIMEOUT_RESET = 16'd120;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_WRITE,
    CMD_KILL,
    CMD_SHIFT
  } cell_cmd_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_FETCH,
    S_COMPACT,
    S_RESP
  } state_t;

  // Contents of one table entry.
  typedef struct packed {
    logic [31:0] request_id;
    logic [7:0]  request_class;
    logic [31:0] handler;
    logic [31:0] stamp;
  } entry_t;

  // Operands shared by all cells.
  typedef struct packed {
    cell_cmd_t   cmd;
    logic [31:0] request_id;
    logic [7:0]  request_class;
    logic [31:0] handler_tag;
    logic [31:0] seconds_now;
    logic [15:0] timeout;
  } cell_bus_t;

  // Controls from the sequencer to the datapath.
  typedef struct packed {
    logic      in_ready;
    cell_cmd_t cmd;
    logic      resp_load;
  } ctrl_t;

  // Keep only the lowest set bit (the oldest position in the table).
  function automatic logic [TABLE_DEPTH-1:0] first_one(input logic [TABLE_DEPTH-1:0] v);
    return v & ~(v - {{(TABLE_DEPTH-1){1'b0}}, 1'b1});
  endfunction

endpackage

[rtl/prtt_cell.sv]
// ---------------------------------------------------------------------------
// Pending request table cell
// Holds one entry, checks it against the broadcast operands and can take
// the entry of its upper neighbor when the chain closes up.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module prtt_cell
  import prtt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_bus_t bus,
  input  logic      sel,
  input  logic      shift_en,
  input  entry_t    nbr_entry,
  input  logic      nbr_valid,
  output entry_t    entry,
  output logic      valid,
  output logic      class_hit,
  output logic      id_hit
);

  logic [31:0] age;
  logic        expired;

  // Age check uses the wrapped tick difference.
  assign age       = bus.seconds_now - entry.stamp;
  assign expired   = valid && (age > {16'd0, bus.timeout});
  assign class_hit = valid && (entry.request_class == bus.request_class);
  assign id_hit    = valid && !expired && (entry.request_id == bus.request_id);

  // Valid flag: set on a write, cleared by a fetch when selected or expired, moved on a shift.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (bus.cmd)
        CMD_WRITE: if (sel) valid <= 1'b1;
        CMD_KILL:  if (sel || expired) valid <= 1'b0;
        CMD_SHIFT: if (shift_en) valid <= nbr_valid;
        default:   valid <= valid;
      endcase
    end
  end

  // Entry payload.
  always_ff @(posedge clk) begin
    if (bus.cmd == CMD_WRITE && sel) begin
      entry.request_id    <= bus.request_id;
      entry.request_class <= bus.request_class;
      entry.handler       <= bus.handler_tag;
      entry.stamp         <= bus.seconds_now;
    end else if (bus.cmd == CMD_SHIFT && shift_en) begin
      entry <= nbr_entry;
    end
  end

endmodule

[rtl/prtt_ctrl.sv]
// ---------------------------------------------------------------------------
// Pending request table sequencer
// Steps add and fetch words through update, close-up (fetch only) and result hand-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module prtt_ctrl
  import prtt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] kind,
  input  logic       gap_any,
  input  logic       out_free,
  output ctrl_t      ctl
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (kind == KIND_ADD) begin
            state_next = S_ADD;
          end else if (kind == KIND_FETCH) begin
            state_next = S_FETCH;
          end
        end
      end
      S_ADD:     state_next = S_RESP;
      S_FETCH:   state_next = S_COMPACT;
      S_COMPACT: if (!gap_any) state_next = S_RESP;
      S_RESP:    if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    ctl.in_ready  = 1'b0;
    ctl.cmd       = CMD_HOLD;
    ctl.resp_load = 1'b0;
    unique case (state)
      S_IDLE:    ctl.in_ready = 1'b1;
      S_ADD:     ctl.cmd = CMD_WRITE;
      S_FETCH:   ctl.cmd = CMD_KILL;
      S_COMPACT: if (gap_any) ctl.cmd = CMD_SHIFT;
      S_RESP:    ctl.resp_load = out_free;
      default:   ctl.cmd = CMD_HOLD;
    endcase
  end

endmodule

[rtl/pending_request_table_with_timeout.sv]
// Words are taken only while idle. Tick word: advances the tick counter, no result.
// Add word: written in the add state; the result loads once the output is free.
// Fetch word: updated in the fetch state, then the chain closes its holes (at most
// TABLE_DEPTH), one shift step per cycle, before the result loads the same way.
// Reset clears the table to empty, the tick counter to zero and the timeout to 120.
// ---------------------------------------------------------------------------
// Pending request table with timeout
// Order-kept chain of cells holding outstanding requests, with in-place
// replacement by class, expiry on fetch and close-up after removal.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pending_request_table_with_timeout_defines.svh"

module pending_request_table_with_timeout
  import prtt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       kind,
  input  logic [31:0]      request_id,
  input  logic [7:0]       request_class,
  input  logic [31:0]      handler_tag,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       status,
  output logic [31:0]      found_handler,
  output logic [CNT_W-1:0] entries_in_use,
  input  logic             cfg_write_en,
  input  logic [15:0]      cfg_write_data
);

  ctrl_t                  ctl;
  cell_bus_t              bus;
  logic [15:0]            timeout_seconds;
  logic [31:0]            seconds_now;
  logic [31:0]            op_request_id;
  logic [7:0]             op_class;
  logic [31:0]            op_handler;
  logic [2:0]             res_status;
  logic [31:0]            res_found;
  logic                   in_fire;
  logic                   out_free;

  entry_t                 cell_entry [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] cell_valid;
  logic [TABLE_DEPTH-1:0] class_hit;
  logic [TABLE_DEPTH-1:0] id_hit;
  logic [TABLE_DEPTH-1:0] cell_sel;
  logic [TABLE_DEPTH-1:0] shift_mask;
  logic [TABLE_DEPTH-1:0] holes;
  logic [TABLE_DEPTH-1:0] first_hole;
  logic [TABLE_DEPTH-1:0] replace_vec;
  logic [TABLE_DEPTH-1:0] add_sel;
  logic [TABLE_DEPTH-1:0] kill_vec;
  logic [TABLE_DEPTH-2:0] gap;
  logic                   gap_any;
  logic [31:0]            hit_handler;
  logic                   tick_fire;
  logic [31:0]            seconds_inc;
  logic                   drop_load;
  logic                   miss_out;

  assign in_ready = ctl.in_ready;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Sequencer for update, close-up and result hand-off.
  prtt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .gap_any  (gap_any),
    .out_free (out_free),
    .ctl      (ctl)
  );

  // Timeout register.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_seconds <= TIMEOUT_RESET;
    end else if (cfg_write_en) begin
      timeout_seconds <= cfg_write_data;
    end
  end

  // Tick counter, wraps modulo 2^32.
  always_ff @(posedge clk) begin
    if (rst) begin
      seconds_now <= '0;
    end else if (in_fire && kind == KIND_TICK) begin
      seconds_now <= seconds_now + 32'd1;
    end
  end

  // Operand capture for the word being worked on.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_request_id <= request_id;
      op_class      <= request_class;
      op_handler    <= handler_tag;
    end
  end

  // Broadcast to the chain.
  always_comb begin
    bus.cmd           = ctl.cmd;
    bus.request_id    = op_request_id;
    bus.request_class = op_class;
    bus.handler_tag   = op_handler;
    bus.seconds_now   = seconds_now;
    bus.timeout       = timeout_seconds;
  end

  // Chain of cells; the top cell takes an empty entry on a shift.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t nbr_entry;
    logic   nbr_valid;

    if (i == TABLE_DEPTH - 1) begin : g_top
      assign nbr_entry = '0;
      assign nbr_valid = 1'b0;
    end else begin : g_mid
      assign nbr_entry = cell_entry[i+1];
      assign nbr_valid = cell_valid[i+1];
    end

    prtt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .bus       (bus),
      .sel       (cell_sel[i]),
      .shift_en  (shift_mask[i]),
      .nbr_entry (nbr_entry),
      .nbr_valid (nbr_valid),
      .entry     (cell_entry[i]),
      .valid     (cell_valid[i]),
      .class_hit (class_hit[i]),
      .id_hit    (id_hit[i])
    );
  end

  // Hole tracking: every cell from the first hole upward moves down one step.
  assign holes      = ~cell_valid;
  assign first_hole = first_one(holes);
  assign shift_mask = ~(first_hole - {{(TABLE_DEPTH-1){1'b0}}, 1'b1});
  assign gap        = ~cell_valid[TABLE_DEPTH-2:0] & cell_valid[TABLE_DEPTH-1:1];
  assign gap_any    = |gap;

  // Add: replace the oldest entry of a nonzero class, else append at the first hole, or drop when full.
  assign replace_vec = (op_class != 8'd0) ? first_one(class_hit) : '0;
  assign add_sel     = (|replace_vec) ? replace_vec : first_hole;

  // Fetch: oldest surviving entry with the requested id.
  assign kill_vec = first_one(id_hit);

  always_comb begin
    hit_handler = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_handler = hit_handler | ({32{kill_vec[i]}} & cell_entry[i].handler);
    end
  end

  always_comb begin
    case (ctl.cmd)
      CMD_WRITE: cell_sel = add_sel;
      CMD_KILL:  cell_sel = kill_vec;
      default:   cell_sel = '0;
    endcase
  end

  // Result capture during the update cycle.
  always_ff @(posedge clk) begin
    if (ctl.cmd == CMD_WRITE) begin
      res_found <= '0;
      if (|replace_vec) begin
        res_status <= ST_REPLACED;
      end else if (|holes) begin
        res_status <= ST_APPENDED;
      end else begin
        res_status <= ST_DROPPED;
      end
    end else if (ctl.cmd == CMD_KILL) begin
      res_found  <= hit_handler;
      res_status <= (|kill_vec) ? ST_HIT : ST_MISS;
    end
  end

  // Output register; the table is closed up by the time it loads.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.resp_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.resp_load) begin
      status         <= res_status;
      found_handler  <= res_found;
      entries_in_use <= CNT_W'($countones(cell_valid));
    end
  end

  // Terms used by the checks below.
  assign tick_fire   = in_fire && (kind == KIND_TICK);
  assign seconds_inc = seconds_now + 32'd1;
  assign drop_load   = ctl.resp_load && (res_status == ST_DROPPED);
  assign miss_out    = out_valid && (status != ST_HIT);

  // Checks on the table logic.
  `PRTT_ASSERT(a_idle_packed, clk, rst, in_ready |-> !gap_any, "table not packed while idle")
  `PRTT_ASSERT_ALWAYS(a_sel_onehot, clk, $onehot0(cell_sel), "more than one cell selected")
  `PRTT_ASSERT(a_tick_step, clk, rst, tick_fire |=> seconds_now == $past(seconds_inc), "tick missed")
  `PRTT_ASSERT(a_drop_full, clk, rst, drop_load |-> &cell_valid, "add dropped with free cell")
  `PRTT_ASSERT(a_found_zero, clk, rst, miss_out |-> found_handler == 32'd0, "stray handler")

endmodule
